/* rtl/bss_pkg.sv */
// ----------------------------------------------------------------------------
// bss_pkg: shared constants for block sample statistics
// Field widths, block limit and datapath sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  localparam int unsigned MaxSamples  = 4096;
  localparam int unsigned SampleBits  = 24;
  localparam int unsigned PosBits     = 12;
  localparam int unsigned CountBits   = 13;
  localparam int unsigned SumBits     = 36;
  localparam int unsigned PowerBits   = 59;
  localparam int unsigned VarBits     = 48;
  localparam int unsigned UnitBits    = 72;
  localparam int unsigned OutDataBits = 264;

endpackage

`default_nettype wire

/* rtl/block_sample_statistics_top.sv */
// ----------------------------------------------------------------------------
// block_sample_statistics_top: per-block min, max, mean, power, rms, variance
// Accumulates a block of samples and reports its statistics on the last one.
// ----------------------------------------------------------------------------
//  Channel | Dir | Contents
//  s_*     | in  | tdata[23:0] sample, tlast last
//  m_*     | out | tdata min/pos/max/pos/mean/power/rms/var/std/count, tuser
//
//  A sample is accepted, then its square is accumulated, before the next is taken.
//  A closing sample then runs its divides, square roots and shift-add multiplies
//  on the shared 72-bit add/subtract unit.
//  Reset clears accumulators; no clearing pass.
//  A waiting result holds only a following closing sample, not ordinary ones.
`default_nettype none

module block_sample_statistics_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_tvalid_i,
  output logic                              s_tready_o,
  // [23:0] sample
  input  wire logic [23:0]                  s_tdata_i,
  input  wire logic                         s_tlast_i,
  output logic                              m_tvalid_o,
  input  wire logic                         m_tready_i,
  // [23:0] min_value, [35:24] min_position, [59:36] max_value,
  // [71:60] max_position, [95:72] mean, [154:96] power, [178:155] rms,
  // [226:179] variance, [250:227] std_deviation, [263:251] sample_count
  output logic [bss_pkg::OutDataBits-1:0]   m_tdata_o,
  // [0] variance_valid
  output logic                              m_tuser_o
);
  import bss_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSq   = 4'd1;
  localparam logic [3:0] StMean = 4'd2;
  localparam logic [3:0] StPowd = 4'd3;
  localparam logic [3:0] StRms  = 4'd4;
  localparam logic [3:0] StNp   = 4'd5;
  localparam logic [3:0] StSs   = 4'd6;
  localparam logic [3:0] StVdiv = 4'd7;
  localparam logic [3:0] StSd   = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;

  logic [3:0]                  state_q;
  logic                        out_valid_q;
  logic [CountBits-1:0]        seen_q;
  logic signed [SumBits-1:0]   sum_q;
  logic [PowerBits-1:0]        sqsum_q;
  logic signed [SampleBits-1:0] min_q, max_q;
  logic [PosBits-1:0]          min_pos_q, max_pos_q;

  logic [UnitBits-1:0]         rem_q, sh_q, res_q;
  logic [UnitBits-1:0]         rem_d, sh_d, res_d;
  logic [6:0]                  cnt_q, cnt_d;
  logic [25:0]                 dv_q;
  logic [47:0]                 prod_q;
  logic                        end_q;
  logic [SampleBits-1:0]       mean_q, rms_q, sd_q;
  logic [VarBits-1:0]          var_q;
  logic                        vvalid_q;
  logic [OutDataBits-1:0]      data_q;
  logic                        user_q;

  logic                        in_acc, out_load, last_step;
  logic signed [SampleBits-1:0] smp;
  logic [CountBits-1:0]        seen_inc;
  logic                        sum_neg;
  logic [SumBits-1:0]          sum_mag;
  logic [UnitBits-1:0]         alu_a, alu_b, q_next;
  logic                        alu_sub;
  logic [UnitBits:0]           alu_sum;
  logic                        alu_ge;
  logic [UnitBits-1:0]         step_rem, step_sh, step_res;
  logic [SumBits-1:0]          mean_mag;

  assign smp        = s_tdata_i;
  assign s_tready_o = (state_q == StIdle);
  assign in_acc     = s_tvalid_i & s_tready_o;
  assign out_load   = (state_q == StOut) & (~out_valid_q | m_tready_i);
  assign last_step  = (cnt_q == 7'd1);
  assign seen_inc   = seen_q + 1'b1;
  assign sum_neg    = sum_q[SumBits-1];
  assign sum_mag    = sum_neg ? SumBits'(-sum_q) : SumBits'(sum_q);

  // Shared add/subtract unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      StMean, StPowd, StVdiv: begin
        alu_a   = {rem_q[UnitBits-2:0], sh_q[UnitBits-1]};
        alu_b   = {{(UnitBits-26){1'b0}}, dv_q};
        alu_sub = 1'b1;
      end
      StRms, StSd: begin
        alu_a   = {rem_q[UnitBits-3:0], sh_q[UnitBits-1:UnitBits-2]};
        alu_b   = {res_q[UnitBits-3:0], 2'b01};
        alu_sub = 1'b1;
      end
      StNp, StSs: begin
        alu_a   = rem_q;
        alu_b   = sh_q[0] ? res_q : '0;
        alu_sub = (state_q == StSs);
      end
      default: begin
        alu_a   = '0;
      end
    endcase
    alu_sum = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b}
              + {{UnitBits{1'b0}}, alu_sub};
    alu_ge  = alu_sum[UnitBits];
  end

  assign q_next   = {res_q[UnitBits-2:0], alu_ge};
  assign mean_mag = q_next[SumBits-1:0];

  always_comb begin
    step_rem = rem_q;
    step_sh  = sh_q;
    step_res = res_q;
    unique case (state_q)
      StMean, StPowd, StVdiv: begin
        step_rem = alu_ge ? alu_sum[UnitBits-1:0] : alu_a;
        step_sh  = {sh_q[UnitBits-2:0], 1'b0};
        step_res = q_next;
      end
      StRms, StSd: begin
        step_rem = alu_ge ? alu_sum[UnitBits-1:0] : alu_a;
        step_sh  = {sh_q[UnitBits-3:0], 2'b00};
        step_res = q_next;
      end
      StNp, StSs: begin
        step_rem = alu_sum[UnitBits-1:0];
        step_sh  = {1'b0, sh_q[UnitBits-1:1]};
        step_res = {res_q[UnitBits-2:0], 1'b0};
      end
      default: begin
        step_rem = rem_q;
      end
    endcase
  end

  // Load the operands of the next operation on its last step
  always_comb begin
    rem_d = step_rem;
    sh_d  = step_sh;
    res_d = step_res;
    cnt_d = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
    unique case (state_q)
      StSq: begin
        rem_d = '0;
        res_d = '0;
        sh_d  = {sum_mag, {(UnitBits-SumBits){1'b0}}};
        cnt_d = 7'(SumBits);
      end
      StMean: begin
        if (last_step) begin
          rem_d = '0;
          res_d = '0;
          sh_d  = {sqsum_q, {(UnitBits-PowerBits){1'b0}}};
          cnt_d = 7'(PowerBits);
        end
      end
      StPowd, StVdiv: begin
        if (last_step) begin
          rem_d = '0;
          res_d = '0;
          sh_d  = {q_next[47:0], 24'b0};
          cnt_d = 7'd24;
        end
      end
      StRms: begin
        if (last_step) begin
          rem_d = '0;
          res_d = {{(UnitBits-PowerBits){1'b0}}, sqsum_q};
          sh_d  = {{(UnitBits-CountBits){1'b0}}, seen_q};
          cnt_d = 7'(CountBits);
        end
      end
      StNp: begin
        if (last_step) begin
          res_d = {{(UnitBits-SumBits){1'b0}}, sum_mag};
          sh_d  = {{(UnitBits-SumBits){1'b0}}, sum_mag};
          cnt_d = 7'(SumBits);
        end
      end
      StSs: begin
        if (last_step) begin
          rem_d = '0;
          res_d = '0;
          sh_d  = alu_sum[UnitBits-1:0];
          cnt_d = 7'(UnitBits);
        end
      end
      StSd: begin
        rem_d = step_rem;
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // Control and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      seen_q      <= '0;
      sum_q       <= '0;
      sqsum_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      min_pos_q   <= '0;
      max_pos_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (seen_q == '0) begin
              min_q     <= smp;
              max_q     <= smp;
              min_pos_q <= '0;
              max_pos_q <= '0;
            end else begin
              if (smp < min_q) begin
                min_q     <= smp;
                min_pos_q <= seen_q[PosBits-1:0];
              end
              if (smp > max_q) begin
                max_q     <= smp;
                max_pos_q <= seen_q[PosBits-1:0];
              end
            end
            sum_q   <= sum_q + SumBits'(smp);
            seen_q  <= seen_inc;
            state_q <= StSq;
          end
        end
        StSq: begin
          sqsum_q <= sqsum_q + {{(PowerBits-48){1'b0}}, prod_q};
          state_q <= end_q ? StMean : StIdle;
        end
        StMean: if (last_step) state_q <= StPowd;
        StPowd: if (last_step) state_q <= StRms;
        StRms: begin
          if (last_step) state_q <= (seen_q == CountBits'(1)) ? StOut : StNp;
        end
        StNp:   if (last_step) state_q <= StSs;
        StSs:   if (last_step) state_q <= StVdiv;
        StVdiv: if (last_step) state_q <= StSd;
        StSd:   if (last_step) state_q <= StOut;
        StOut: begin
          if (out_load) begin
            seen_q    <= '0;
            sum_q     <= '0;
            sqsum_q   <= '0;
            min_q     <= '0;
            max_q     <= '0;
            min_pos_q <= '0;
            max_pos_q <= '0;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Shared unit registers and results
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    res_q <= res_d;
    cnt_q <= cnt_d;
    if (in_acc) begin
      prod_q <= 48'(smp * smp);
      end_q  <= s_tlast_i | (seen_inc == CountBits'(MaxSamples));
    end
    unique case (state_q)
      StSq: begin
        dv_q <= {{(26-CountBits){1'b0}}, seen_q};
      end
      StMean: begin
        if (last_step) begin
          mean_q <= sum_neg ? SampleBits'(-mean_mag) : mean_mag[SampleBits-1:0];
        end
      end
      StRms: begin
        if (last_step) begin
          rms_q    <= q_next[SampleBits-1:0];
          var_q    <= '0;
          sd_q     <= '0;
          vvalid_q <= (seen_q != CountBits'(1));
        end
      end
      StSs: begin
        if (last_step) dv_q <= 26'(seen_q * (seen_q - 1'b1));
      end
      StVdiv: begin
        if (last_step) var_q <= q_next[VarBits-1:0];
      end
      StSd: begin
        if (last_step) sd_q <= q_next[SampleBits-1:0];
      end
      StOut: begin
        if (out_load) begin
          data_q <= {seen_q, sd_q, var_q, rms_q, sqsum_q, mean_q,
                     max_pos_q, max_q, min_pos_q, min_q};
          user_q <= vvalid_q;
        end
      end
      default: begin
        user_q <= user_q;
      end
    endcase
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = user_q;

endmodule

`default_nettype wire

/* rtl/bss_checker.sv */
// ----------------------------------------------------------------------------
// bss_checker: port-level checks for block sample statistics
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_tvalid_i,
  input wire logic         s_tready_o,
  input wire logic         m_tvalid_o,
  input wire logic         m_tready_i,
  input wire logic [263:0] m_tdata_o,
  input wire logic         m_tuser_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("stalled result changed");

  // ready drops after every accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("request accepted on back-to-back cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tdata_o[263:251] != 13'd0)
    else $error("result with zero sample count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tuser_o |-> m_tdata_o[226:179] == 48'd0
                              && m_tdata_o[250:227] == 24'd0
                              && m_tdata_o[263:251] == 13'd1)
    else $error("invalid variance not zero or block not single");

endmodule

bind block_sample_statistics_top bss_checker u_bss_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);

`default_nettype wire

/* test/block_sample_statistics_checker.sv */
// ----------------------------------------------------------------------------
// block_sample_statistics_checker: statistics predictor and result compare
// Watches both stream channels, predicts each block result from the accepted
// samples and compares it with the delivered result, showing fields on a mismatch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_sample_statistics_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_tvalid_i,
  input  wire logic                               s_tready_i,
  input  wire logic [23:0]                        s_tdata_i,
  input  wire logic                               s_tlast_i,
  input  wire logic                               m_tvalid_i,
  input  wire logic                               m_tready_i,
  input  wire logic [bss_pkg::OutDataBits-1:0]    m_tdata_i,
  input  wire logic                               m_tuser_i,
  output int                                      pending_o,
  output int                                      errors_o,
  output int                                      results_o
);
  import bss_pkg::*;

  typedef struct packed {
    logic        var_valid;
    logic [12:0] count;
    logic [23:0] std_dev;
    logic [47:0] variance;
    logic [23:0] rms;
    logic [58:0] power;
    logic [23:0] mean;
    logic [11:0] max_pos;
    logic [23:0] max_val;
    logic [11:0] min_pos;
    logic [23:0] min_val;
  } block_stats_t;

  block_stats_t stats_q[$];

  logic signed [63:0] sum_acc;
  logic [63:0]        sq_acc;
  logic signed [23:0] lo_val, hi_val;
  logic [11:0]        lo_pos, hi_pos;
  int unsigned        n_seen;

  function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
    logic [127:0] r, b, x;
    r = 0;
    x = v;
    b = 128'd1 << 126;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[63:0];
  endfunction

  function automatic block_stats_t close_block(input logic signed [63:0] sum,
                                               input logic [63:0] sq,
                                               input int unsigned n);
    block_stats_t r;
    logic signed [63:0] mean_w;
    logic [127:0] num, den, var_w;
    logic [63:0] root;
    r = '0;
    mean_w = sum / $signed({32'd0, n});
    r.mean = mean_w[23:0];
    r.power = sq[58:0];
    root = floor_sqrt({64'd0, sq / n});
    r.rms = root[23:0];
    r.count = n[12:0];
    if (n > 1) begin
      num = 128'(n) * 128'(sq) - 128'(sum) * 128'(sum);
      den = 128'(n) * 128'(n - 1);
      var_w = num / den;
      r.variance = var_w[47:0];
      root = floor_sqrt(var_w);
      r.std_dev = root[23:0];
      r.var_valid = 1'b1;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    block_stats_t e;
    block_stats_t got;
    logic signed [23:0] s;
    if (!rst_ni) begin
      sum_acc <= 0;
      sq_acc <= 0;
      lo_val <= 0;
      hi_val <= 0;
      lo_pos <= 0;
      hi_pos <= 0;
      n_seen <= 0;
      errors_o <= 0;
      results_o <= 0;
      stats_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        s = s_tdata_i;
        e = '0;
        if (n_seen == 0) begin
          e.min_val = s;
          e.max_val = s;
        end else begin
          e.min_val = (s < lo_val) ? s : lo_val;
          e.min_pos = (s < lo_val) ? n_seen[11:0] : lo_pos;
          e.max_val = (s > hi_val) ? s : hi_val;
          e.max_pos = (s > hi_val) ? n_seen[11:0] : hi_pos;
        end
        if (s_tlast_i || n_seen + 1 >= MaxSamples) begin
          got = close_block(sum_acc + s, sq_acc + 64'(s * s), n_seen + 1);
          got.min_val = e.min_val;
          got.min_pos = e.min_pos;
          got.max_val = e.max_val;
          got.max_pos = e.max_pos;
          stats_q.push_back(got);
          sum_acc <= 0;
          sq_acc <= 0;
          n_seen <= 0;
        end else begin
          sum_acc <= sum_acc + s;
          sq_acc <= sq_acc + 64'(s * s);
          n_seen <= n_seen + 1;
          lo_val <= e.min_val;
          lo_pos <= e.min_pos;
          hi_val <= e.max_val;
          hi_pos <= e.max_pos;
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tuser_i, m_tdata_i};
        results_o <= results_o + 1;
        if (stats_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          errors_o <= errors_o + 1;
        end else begin
          e = stats_q.pop_front();
          if (got !== e) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, e, got);
            $display("  min %0d/%0d max %0d/%0d mean %0d pow %0d rms %0d",
                     $signed(e.min_val), e.min_pos, $signed(e.max_val), e.max_pos,
                     $signed(e.mean), e.power, e.rms);
            $display("  var %0d std %0d n %0d ok %0b | got var %0d std %0d n %0d",
                     e.variance, e.std_dev, e.count, e.var_valid,
                     got.variance, got.std_dev, got.count);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = stats_q.size();

endmodule

/* test/block_sample_statistics_top_tb.sv */
// ----------------------------------------------------------------------------
// block_sample_statistics_top_tb: stimulus and verdict for sample statistics
// Sends directed and random sample blocks with random stalls on both sides;
// the checker predicts and compares every block result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_sample_statistics_top_tb;
  import bss_pkg::*;

  localparam int LimitCycles = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid_i = 1'b0;
  logic [23:0] s_tdata_i = '0;
  logic s_tlast_i = 1'b0;
  logic m_tready_i = 1'b0;
  wire  s_tready_o, m_tvalid_o, m_tuser_o;
  wire  [OutDataBits-1:0] m_tdata_o;
  int   pending, errors, results;
  int   cycles = 0;
  int   send_idle, recv_idle, sent;

  always #1 clk_i = ~clk_i;

  block_sample_statistics_top uut (.*);

  block_sample_statistics_checker chk (
    .clk_i, .rst_ni,
    .s_tvalid_i, .s_tready_i(s_tready_o), .s_tdata_i, .s_tlast_i,
    .m_tvalid_i(m_tvalid_o), .m_tready_i, .m_tdata_i(m_tdata_o), .m_tuser_i(m_tuser_o),
    .pending_o(pending), .errors_o(errors), .results_o(results)
  );

  // receiver stall, redrawn every cycle
  always @(posedge clk_i) m_tready_i <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_sample(input logic [23:0] d, input logic l);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= d;
    s_tlast_i <= l;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(16)) - 8);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_block(input int len);
    for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int len;
    sent = 0;
    send_idle = 0;
    recv_idle = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // single-sample blocks at the extremes, then ties and both signs
    send_sample(24'h7FFFFF, 1'b1);
    send_sample(24'h800000, 1'b1);
    send_sample(24'h000000, 1'b1);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h800000, 1'b1);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b1);
    send_sample(24'h000005, 1'b0);
    send_sample(24'hFFFFFB, 1'b0);
    send_sample(24'h000005, 1'b0);
    send_sample(24'hFFFFFF, 1'b1);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'hFFFFFE, 1'b1);
    drain();
    send_block(3);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 37 : (ph == 1) ? 76 : 0;
      recv_idle = (ph == 0) ? 76 : (ph == 1) ? 37 : 0;
      for (int b = 0; b < 32; b++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        send_block(len);
        if (b == 16) drain();
      end
    end
    drain();
    repeat (600) @(posedge clk_i);
    $display("Sent %0d samples in directed and random blocks;", sent);
    $display("checked %0d block results under three stall patterns.", results);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* block_sample_statistics_top.f */
rtl/bss_pkg.sv
rtl/block_sample_statistics_top.sv
rtl/bss_checker.sv
test/block_sample_statistics_checker.sv
test/block_sample_statistics_top_tb.sv
